// ===== src/interlocked_contactor_relay_timer_assert.svh =====
// Assertion macros shared by the relay timer modules.
`ifndef INTERLOCKED_CONTACTOR_RELAY_TIMER_ASSERT_SVH
`define INTERLOCKED_CONTACTOR_RELAY_TIMER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ICRT_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define ICRT_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/icrt_pkg.sv =====
// Shared types and constants of the interlocked contactor relay timer.
package icrt_pkg;

  localparam int RELAY_COUNT_DEF = 8;
  localparam int RIDX_W          = 3;
  localparam int TIME_W          = 32;
  localparam int SECS_W          = 23;
  localparam int TMO_W           = 24;
  localparam int CFG_W           = 64;
  localparam int PROD_W          = 61;
  localparam int DIV1000_SHIFT   = 38;

  // Multiplying by this and shifting right by DIV1000_SHIFT divides any
  // 32-bit value by 1000 exactly.
  localparam logic [28:0]       DIV1000_MUL = 29'd274877907;
  localparam logic [TMO_W-1:0]  MS_PER_MIN  = 24'd60000;
  localparam logic [TIME_W-1:0] DELAY_RESET = 32'd30000;
  localparam logic [RIDX_W-1:0] TP_RESET    = 3'd1;
  localparam logic [RIDX_W-1:0] SP_RESET    = 3'd2;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_TRIG = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_DELAY   = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_TP_IDX  = 2'd2,
    REG_SP_IDX  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] delay;
    logic [CFG_W-1:0]  tmo_packed;
    logic [RIDX_W-1:0] tp;
    logic [RIDX_W-1:0] sp;
  } cfg_t;

  // Per-relay record held in the main state memory.
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic              start_valid;
    logic [TIME_W-1:0] expiry;
  } rec_t;

  typedef struct packed {
    logic [RIDX_W-1:0] addr;
    logic              a_re;
    logic              a_we;
    rec_t              a_wdata;
    logic              b_re;
    logic              b_we;
    logic [TIME_W-1:0] b_wdata;
  } store_req_t;

  typedef struct packed {
    logic [RIDX_W-1:0] relay;
    logic              on;
    logic [SECS_W-1:0] secs;
    logic              known;
  } res_t;

  typedef struct packed {
    logic accept_ok;
    logic empty;
  } oq_stat_t;

endpackage

// ===== src/icrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module icrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/icrt_store.sv =====
// Relay state store: record memory, stop-time memory and their valid bits.
`include "interlocked_contactor_relay_timer_assert.svh"

module icrt_store #(
  parameter int RELAY_COUNT = icrt_pkg::RELAY_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  icrt_pkg::store_req_t          req,
  output icrt_pkg::rec_t                a_rdata,
  output logic [icrt_pkg::TIME_W-1:0]   b_rdata
);

  localparam int AW = $clog2(RELAY_COUNT);
  localparam int RW = $bits(icrt_pkg::rec_t);

  logic [AW-1:0]               addr;
  logic [RELAY_COUNT-1:0]      a_vld_r, a_vld_nxt;
  logic [RELAY_COUNT-1:0]      b_vld_r, b_vld_nxt;
  logic                        a_rv_r, a_rv_nxt;
  logic                        b_rv_r, b_rv_nxt;
  logic [RW-1:0]               a_raw;
  logic [icrt_pkg::TIME_W-1:0] b_raw;

  assign addr = req.addr[AW-1:0];

  icrt_ram #(.WIDTH(RW), .DEPTH(RELAY_COUNT)) u_rec_ram (
    .clk   (clk),
    .we    (req.a_we),
    .waddr (addr),
    .wdata (req.a_wdata),
    .re    (req.a_re),
    .raddr (addr),
    .rdata (a_raw)
  );

  icrt_ram #(.WIDTH(icrt_pkg::TIME_W), .DEPTH(RELAY_COUNT)) u_stop_ram (
    .clk   (clk),
    .we    (req.b_we),
    .waddr (addr),
    .wdata (req.b_wdata),
    .re    (req.b_re),
    .raddr (addr),
    .rdata (b_raw)
  );

  // An entry never written since reset reads as zero.
  always_comb begin
    a_vld_nxt = a_vld_r;
    b_vld_nxt = b_vld_r;
    a_rv_nxt  = a_rv_r;
    b_rv_nxt  = b_rv_r;
    if (req.a_we) begin
      a_vld_nxt[addr] = 1'b1;
    end
    if (req.b_we) begin
      b_vld_nxt[addr] = 1'b1;
    end
    if (req.a_re) begin
      a_rv_nxt = a_vld_r[addr];
    end
    if (req.b_re) begin
      b_rv_nxt = b_vld_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
      b_vld_r <= '0;
      a_rv_r  <= 1'b0;
      b_rv_r  <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
      a_rv_r  <= a_rv_nxt;
      b_rv_r  <= b_rv_nxt;
    end
  end

  assign a_rdata = a_rv_r ? icrt_pkg::rec_t'(a_raw) : '0;
  assign b_rdata = b_rv_r ? b_raw : '0;

  // The sequencer never reads and writes one memory in the same cycle.
  `ICRT_AST_IMP(a_rec_no_overlap, req.a_we, !req.a_re, "record memory read during write")
  `ICRT_AST_IMP(a_stop_no_overlap, req.b_we, !req.b_re, "stop memory read during write")

endmodule

// ===== src/icrt_outq.sv =====
// Result staging: one held result plus the output register.
`include "interlocked_contactor_relay_timer_assert.svh"

module icrt_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          emit,
  input  logic                          flush,
  input  icrt_pkg::res_t                new_res,
  output icrt_pkg::oq_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [icrt_pkg::RIDX_W-1:0]   out_changed_relay,
  output logic                          out_relay_on,
  output logic [icrt_pkg::SECS_W-1:0]   out_run_seconds,
  output logic                          out_run_known,
  output logic                          out_last_change
);

  icrt_pkg::res_t hold_r, hold_nxt;
  icrt_pkg::res_t out_r, out_nxt;
  logic           hold_v_r, hold_v_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_free;

  // A result is held back until the next one appears or the item ends, so
  // that the last one can carry the final mark.
  always_comb begin
    out_free       = !out_valid_r || out_ready;
    stat.accept_ok = !hold_v_r || out_free;
    stat.empty     = !hold_v_r;
    hold_nxt       = hold_r;
    hold_v_nxt     = hold_v_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (emit && stat.accept_ok) begin
      if (hold_v_r) begin
        out_nxt       = hold_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      hold_nxt   = new_res;
      hold_v_nxt = 1'b1;
    end else if (flush && hold_v_r && out_free) begin
      out_nxt       = hold_r;
      out_last_nxt  = 1'b1;
      out_valid_nxt = 1'b1;
      hold_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_changed_relay = out_r.relay;
  assign out_relay_on      = out_r.on;
  assign out_run_seconds   = out_r.secs;
  assign out_run_known     = out_r.known;
  assign out_last_change   = out_last_r;

  `ICRT_AST_NXT(a_flush_marks_last, flush && hold_v_r && out_free && !emit,
    out_valid_r && out_last_r && !hold_v_r, "final result not marked on flush")
  `ICRT_AST_NXT(a_emit_pushes_held, emit && hold_v_r,
    out_valid_r && !out_last_r && hold_v_r, "held result lost on emit")

endmodule

// ===== src/icrt_seq.sv =====
// Sequencer: walks the relays and runs interlock, timeout and switching steps.
`include "interlocked_contactor_relay_timer_assert.svh"

module icrt_seq #(
  parameter int RELAY_COUNT = icrt_pkg::RELAY_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  icrt_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic [icrt_pkg::RIDX_W-1:0]   in_relay_index,
  input  logic                          in_turn_on,
  output icrt_pkg::store_req_t          req,
  input  icrt_pkg::rec_t                a_rdata,
  input  logic [icrt_pkg::TIME_W-1:0]   b_rdata,
  output logic                          emit,
  output logic                          flush,
  output icrt_pkg::res_t                res,
  input  icrt_pkg::oq_stat_t            oq
);

  localparam int AW = $clog2(RELAY_COUNT);
  localparam logic [3:0]    RC_L = 4'(RELAY_COUNT);
  localparam logic [AW-1:0] LAST = AW'(RELAY_COUNT - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_WALK, S_ISTEP, S_DT_T, S_DT_S, S_DT_EV, S_CHK_RD, S_CHK_EV,
    S_SET, S_DRV, S_DRV_RD, S_DRV_MUL, S_DRV_SEC, S_EMIT,
    S_TRIG_RD, S_TRIG_WR, S_CLR_RD, S_CLR_WR, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    RET_DONE, RET_TRIG, RET_CLR, RET_CHECK
  } ret_t;

  state_t                        state_r, state_nxt;
  ret_t                          ret_r, ret_nxt;
  logic [icrt_pkg::TIME_W-1:0]   time_r, time_nxt;
  logic [RELAY_COUNT-1:0]        on_r, on_nxt;
  logic                          sw_r, sw_nxt;
  logic                          tw_r, tw_nxt;
  logic                          pend_r, pend_nxt;
  logic [AW-1:0]                 i_r, i_nxt;
  logic [icrt_pkg::RIDX_W-1:0]   d_idx_r, d_idx_nxt;
  logic                          d_on_r, d_on_nxt;
  logic                          tgt3_r, tgt3_nxt;
  logic                          over_t_r, over_t_nxt;
  logic [icrt_pkg::TMO_W-1:0]    tmo_r, tmo_nxt;
  logic [icrt_pkg::TIME_W-1:0]   diff_r, diff_nxt;
  logic                          known_r, known_nxt;
  logic [icrt_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  icrt_pkg::res_t                res_r, res_nxt;

  logic                          active;
  logic [AW-1:0]                 tpi, spi, di;
  logic [7:0]                    mins;
  logic [icrt_pkg::TIME_W-1:0]   elapsed;
  logic [icrt_pkg::TIME_W-1:0]   since_exp;
  logic [28:0]                   div_k;

  function automatic state_t ret_target(ret_t r);
    state_t s;
    unique case (r)
      RET_DONE:  s = S_FIN;
      RET_TRIG:  s = S_TRIG_RD;
      RET_CLR:   s = S_CLR_RD;
      RET_CHECK: s = S_CHK_RD;
    endcase
    return s;
  endfunction

  assign active = (4'(cfg.tp) < RC_L) && (4'(cfg.sp) < RC_L) && (cfg.tp != cfg.sp);
  assign tpi    = cfg.tp[AW-1:0];
  assign spi    = cfg.sp[AW-1:0];
  assign di     = d_idx_r[AW-1:0];
  assign mins   = cfg.tmo_packed[{in_relay_index, 3'b000} +: 8];
  assign elapsed   = time_r - b_rdata;
  assign since_exp = time_r - a_rdata.expiry;
  assign div_k     = icrt_pkg::DIV1000_MUL;

  assign in_ready = (state_r == S_IDLE);
  assign res      = res_r;

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    time_nxt   = time_r;
    on_nxt     = on_r;
    sw_nxt     = sw_r;
    tw_nxt     = tw_r;
    pend_nxt   = pend_r;
    i_nxt      = i_r;
    d_idx_nxt  = d_idx_r;
    d_on_nxt   = d_on_r;
    tgt3_nxt   = tgt3_r;
    over_t_nxt = over_t_r;
    tmo_nxt    = tmo_r;
    diff_nxt   = diff_r;
    known_nxt  = known_r;
    prod_nxt   = prod_r;
    res_nxt    = res_r;
    req        = '0;
    emit       = 1'b0;
    flush      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          d_idx_nxt = in_relay_index;
          d_on_nxt  = in_turn_on;
          tmo_nxt   = icrt_pkg::TMO_W'(mins) * icrt_pkg::MS_PER_MIN;
          i_nxt     = '0;
          unique case (in_operation)
            icrt_pkg::OP_TICK: begin
              time_nxt  = time_r + 32'd1;
              state_nxt = S_WALK;
            end
            icrt_pkg::OP_SET: begin
              if (4'(in_relay_index) < RC_L) begin
                ret_nxt   = RET_DONE;
                state_nxt = S_SET;
              end
            end
            icrt_pkg::OP_TRIG: begin
              if (4'(in_relay_index) < RC_L) begin
                ret_nxt   = (in_turn_on && mins != 8'd0) ? RET_TRIG : RET_DONE;
                state_nxt = S_SET;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_WALK: begin
        if (pend_r && active && (3'(i_r) == cfg.tp || 3'(i_r) == cfg.sp)) begin
          state_nxt = S_ISTEP;
        end else begin
          req.addr  = 3'(i_r);
          req.a_re  = 1'b1;
          state_nxt = S_CHK_EV;
        end
      end

      S_ISTEP: begin
        if (tw_r && !on_r[tpi]) begin
          if (on_r[spi]) begin
            d_idx_nxt = cfg.sp;
            d_on_nxt  = 1'b0;
            ret_nxt   = RET_CHECK;
            state_nxt = S_DRV;
          end else begin
            tgt3_nxt  = 1'b1;
            state_nxt = S_DT_T;
          end
        end else if (sw_r && !on_r[spi] && !on_r[tpi]) begin
          tgt3_nxt  = 1'b0;
          state_nxt = S_DT_T;
        end else begin
          state_nxt = S_CHK_RD;
        end
      end

      S_DT_T: begin
        req.addr  = cfg.tp;
        req.b_re  = 1'b1;
        state_nxt = S_DT_S;
      end

      S_DT_S: begin
        over_t_nxt = (elapsed >= cfg.delay);
        req.addr   = cfg.sp;
        req.b_re   = 1'b1;
        state_nxt  = S_DT_EV;
      end

      S_DT_EV: begin
        if (over_t_r && (elapsed >= cfg.delay)) begin
          pend_nxt  = 1'b0;
          d_idx_nxt = tgt3_r ? cfg.tp : cfg.sp;
          d_on_nxt  = 1'b1;
          ret_nxt   = RET_CHECK;
          state_nxt = S_DRV;
        end else begin
          state_nxt = S_CHK_RD;
        end
      end

      S_CHK_RD: begin
        req.addr  = 3'(i_r);
        req.a_re  = 1'b1;
        state_nxt = S_CHK_EV;
      end

      S_CHK_EV: begin
        if (a_rdata.expiry != '0 && !since_exp[icrt_pkg::TIME_W-1]) begin
          d_idx_nxt = 3'(i_r);
          d_on_nxt  = 1'b0;
          ret_nxt   = RET_CLR;
          state_nxt = S_SET;
        end else if (i_r == LAST) begin
          state_nxt = S_FIN;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_WALK;
        end
      end

      S_SET: begin
        if (active && (d_idx_r == cfg.tp || d_idx_r == cfg.sp)) begin
          if (d_idx_r == cfg.sp) begin
            sw_nxt = d_on_r;
            if (d_on_r && !on_r[spi]) begin
              pend_nxt = 1'b1;
            end
          end else begin
            tw_nxt = d_on_r;
            if (d_on_r && !on_r[tpi]) begin
              pend_nxt = 1'b1;
            end else if (!d_on_r && sw_r) begin
              pend_nxt = 1'b1;
            end
          end
          state_nxt = d_on_r ? ret_target(ret_r) : S_DRV;
        end else begin
          state_nxt = S_DRV;
        end
      end

      S_DRV: begin
        if (on_r[di] == d_on_r) begin
          state_nxt = ret_target(ret_r);
        end else if (d_on_r) begin
          req.addr    = d_idx_r;
          req.a_we    = 1'b1;
          req.a_wdata = '{start_time: time_r, start_valid: 1'b1, expiry: '0};
          on_nxt[di]  = 1'b1;
          res_nxt     = '{relay: d_idx_r, on: 1'b1, secs: '0, known: 1'b0};
          state_nxt   = S_EMIT;
        end else begin
          req.addr  = d_idx_r;
          req.a_re  = 1'b1;
          state_nxt = S_DRV_RD;
        end
      end

      S_DRV_RD: begin
        diff_nxt    = time_r - a_rdata.start_time;
        known_nxt   = a_rdata.start_valid;
        req.addr    = d_idx_r;
        req.a_we    = 1'b1;
        req.a_wdata = '0;
        req.b_we    = 1'b1;
        req.b_wdata = time_r;
        on_nxt[di]  = 1'b0;
        state_nxt   = S_DRV_MUL;
      end

      S_DRV_MUL: begin
        prod_nxt  = diff_r * div_k;
        state_nxt = S_DRV_SEC;
      end

      S_DRV_SEC: begin
        res_nxt.relay = d_idx_r;
        res_nxt.on    = 1'b0;
        res_nxt.secs  = known_r ? prod_r[icrt_pkg::DIV1000_SHIFT +: icrt_pkg::SECS_W] : '0;
        res_nxt.known = known_r;
        state_nxt     = S_EMIT;
      end

      S_EMIT: begin
        if (oq.accept_ok) begin
          emit      = 1'b1;
          state_nxt = ret_target(ret_r);
        end
      end

      S_TRIG_RD: begin
        req.addr  = d_idx_r;
        req.a_re  = 1'b1;
        state_nxt = S_TRIG_WR;
      end

      S_TRIG_WR: begin
        req.addr           = d_idx_r;
        req.a_we           = 1'b1;
        req.a_wdata        = a_rdata;
        req.a_wdata.expiry = time_r + icrt_pkg::TIME_W'(tmo_r);
        state_nxt          = S_FIN;
      end

      S_CLR_RD: begin
        req.addr  = 3'(i_r);
        req.a_re  = 1'b1;
        state_nxt = S_CLR_WR;
      end

      S_CLR_WR: begin
        req.addr           = 3'(i_r);
        req.a_we           = 1'b1;
        req.a_wdata        = a_rdata;
        req.a_wdata.expiry = '0;
        if (i_r == LAST) begin
          state_nxt = S_FIN;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_WALK;
        end
      end

      S_FIN: begin
        flush = 1'b1;
        if (oq.empty || oq.accept_ok) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      time_r  <= '0;
      on_r    <= '0;
      sw_r    <= 1'b0;
      tw_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      time_r  <= time_nxt;
      on_r    <= on_nxt;
      sw_r    <= sw_nxt;
      tw_r    <= tw_nxt;
      pend_r  <= pend_nxt;
    end
    ret_r    <= ret_nxt;
    i_r      <= i_nxt;
    d_idx_r  <= d_idx_nxt;
    d_on_r   <= d_on_nxt;
    tgt3_r   <= tgt3_nxt;
    over_t_r <= over_t_nxt;
    tmo_r    <= tmo_nxt;
    diff_r   <= diff_nxt;
    known_r  <= known_nxt;
    prod_r   <= prod_nxt;
    res_r    <= res_nxt;
  end

  `ICRT_AST_NXT(a_tick_advances, in_valid && in_ready && in_operation == icrt_pkg::OP_TICK,
    time_r == $past(time_r) + 32'd1, "tick did not advance the clock")
  `ICRT_AST_NXT(a_emit_leaves, state_r == S_EMIT && oq.accept_ok,
    state_r != S_EMIT, "result transfer stuck")

endmodule

// ===== src/interlocked_contactor_relay_timer.sv =====
// Top level of the interlocked contactor relay timer.
// The block drives a bank of relays with optional auto-off timeouts; two of
// them are mutually interlocked contactors with a both-off dead time.
// Items come in on the in_ channel (valid/ready): a millisecond tick, a plain
// set request or a trigger-or-set request. Each real relay change leaves on
// the out_ channel as one transfer; the final transfer of an item carries
// out_last_change. An item with no change produces no transfer at all.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user writes
// it only while idle, which the block itself does not enforce. One item is in
// work at a time. A quiet tick walks the record memory, a read and an evaluate
// step per relay; it also clears each timeout it finds and runs a pending
// interlock step, with or without its dead-time check. A trigger that sets a
// timeout reads and rewrites its record. A switch-on writes the record and
// stages the result; a switch-off reads the record, writes it back, runs the
// divide-by-1000 multiply, forms the result and stages it. A held result moves
// into the output register when the next result is staged or the item ends.
// After reset all relays are off, the clock is zero and the registers hold
// their reset values; the memories need no clearing pass. If the receiver
// stalls, one result waits in the output register and one more is held;
// the walk then pauses at the next change until a transfer frees a place.
module interlocked_contactor_relay_timer #(
  parameter int RELAY_COUNT = icrt_pkg::RELAY_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic [icrt_pkg::RIDX_W-1:0]   in_relay_index,
  input  logic                          in_turn_on,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [icrt_pkg::RIDX_W-1:0]   out_changed_relay,
  output logic                          out_relay_on,
  output logic [icrt_pkg::SECS_W-1:0]   out_run_seconds,
  output logic                          out_run_known,
  output logic                          out_last_change,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [icrt_pkg::CFG_W-1:0]    cfg_wdata
);

  icrt_pkg::cfg_t               cfg_r, cfg_nxt;
  icrt_pkg::store_req_t         req;
  icrt_pkg::rec_t               a_rdata;
  logic [icrt_pkg::TIME_W-1:0]  b_rdata;
  icrt_pkg::res_t               res;
  icrt_pkg::oq_stat_t           oq;
  logic                         emit;
  logic                         flush;

  // Configuration registers: each write replaces the whole register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        icrt_pkg::REG_DELAY:   cfg_nxt.delay      = cfg_wdata[icrt_pkg::TIME_W-1:0];
        icrt_pkg::REG_TIMEOUT: cfg_nxt.tmo_packed = cfg_wdata;
        icrt_pkg::REG_TP_IDX:  cfg_nxt.tp         = cfg_wdata[icrt_pkg::RIDX_W-1:0];
        icrt_pkg::REG_SP_IDX:  cfg_nxt.sp         = cfg_wdata[icrt_pkg::RIDX_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay      <= icrt_pkg::DELAY_RESET;
      cfg_r.tmo_packed <= '0;
      cfg_r.tp         <= icrt_pkg::TP_RESET;
      cfg_r.sp         <= icrt_pkg::SP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer: owns the millisecond clock, the relay on bits and the
  // interlock flags, and steps through the relay records in memory.
  icrt_seq #(.RELAY_COUNT(RELAY_COUNT)) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_relay_index (in_relay_index),
    .in_turn_on     (in_turn_on),
    .req            (req),
    .a_rdata        (a_rdata),
    .b_rdata        (b_rdata),
    .emit           (emit),
    .flush          (flush),
    .res            (res),
    .oq             (oq)
  );

  // Start times, expiry times and stop times, one record per relay.
  icrt_store #(.RELAY_COUNT(RELAY_COUNT)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata)
  );

  // Result staging and output register.
  icrt_outq u_outq (
    .clk               (clk),
    .rst_n             (rst_n),
    .emit              (emit),
    .flush             (flush),
    .new_res           (res),
    .stat              (oq),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_changed_relay (out_changed_relay),
    .out_relay_on      (out_relay_on),
    .out_run_seconds   (out_run_seconds),
    .out_run_known     (out_run_known),
    .out_last_change   (out_last_change)
  );

endmodule
